FILE: hdl/wpl_pkg.sv
// shared types and constants of the windowed peak limit monitor
package wpl_pkg;

   localparam int WINDOWS     = 4;
   localparam int MAX_SAMPLES = 4096;
   localparam int SAMPLE_BITS = 16;

   localparam int IDX_BITS    = $clog2(MAX_SAMPLES);
   localparam int CFG_IDX_BITS = 12;
   localparam int CMP_BITS    = (IDX_BITS > CFG_IDX_BITS) ? IDX_BITS : CFG_IDX_BITS;
   localparam int SUM_BITS    = 28;
   localparam int PEAK_BITS   = 15;
   localparam int OUT_PEAKS   = 4;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 57;

   localparam logic [IDX_BITS-1:0] IDX_MAX = IDX_BITS'(MAX_SAMPLES - 1);

   // register map: window registers follow one another from this index
   localparam logic [CSR_ADDR_BITS-1:0] REG_WINDOW_0 = '0;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [SUM_BITS-1:0]    sum_type;

   // window register layout, enable in bit 0
   typedef struct packed {
      logic signed [15:0] upper;
      logic signed [15:0] lower;
      logic [CFG_IDX_BITS-1:0] end_idx;
      logic [CFG_IDX_BITS-1:0] begin_idx;
      logic enable;
   } window_cfg_type;

endpackage

FILE: hdl/wpl_if.sv
// channel interfaces: sample input, result output and register writes
interface wpl_req_if;
   import wpl_pkg::*;
   logic       valid;
   logic       ready;
   sample_type sample;
   logic       last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface wpl_rsp_if;
   import wpl_pkg::*;
   logic                 valid;
   logic                 ready;
   sum_type              raw_sum;
   logic [PEAK_BITS-1:0] peak_value;
   logic [PEAK_BITS-1:0] window_peak_a;
   logic [PEAK_BITS-1:0] window_peak_b;
   logic [PEAK_BITS-1:0] window_peak_c;
   logic [PEAK_BITS-1:0] window_peak_d;
   logic                 in_limits;

   modport source (output valid, output raw_sum, output peak_value, output window_peak_a,
                   output window_peak_b, output window_peak_c, output window_peak_d,
                   output in_limits, input ready);
   modport sink   (input valid, input raw_sum, input peak_value, input window_peak_a,
                   input window_peak_b, input window_peak_c, input window_peak_d,
                   input in_limits, output ready);
endinterface

interface wpl_csr_if;
   import wpl_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_ADDR_BITS-1:0] reg_index;
   logic [CSR_DATA_BITS-1:0] wr_data;

   modport source (output valid, output reg_index, output wr_data, input ready);
   modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: hdl/windowed_peak_limit_monitor_top.sv
// windowed peak limit monitor: one channel, sum, peaks and window limit check
//
//   channel   dir   payload                                          transaction
//   req_bus   in    sample, last_sample                              valid && ready
//   rsp_bus   out   raw_sum, peak_value, window_peak_a..d, in_limits valid && ready
//   csr_bus   in    reg_index, wr_data (window_0..window_3)          valid && ready
//
// one sample per cycle while no result stalls; a sample is registered on accept and folded
// into record state on advance; a last sample's result shows the cycle after its fold
// reset (synchronous, active high) clears windows, record state and both valid flags
// a stalled result holds the processing stage; the input register takes one more
// sample and then req ready stays low until the result leaves, the csr port is always ready
module windowed_peak_limit_monitor_top (
   input  logic          clock,
   input  logic          reset,
   wpl_req_if.sink       req_bus,
   wpl_rsp_if.source     rsp_bus,
   wpl_csr_if.sink       csr_bus
);
   import wpl_pkg::*;

   // window configuration
   window_cfg_type window_cfg_ff [WINDOWS];

   // input register
   logic       in_valid_ff;
   sample_type in_sample_ff;
   logic       in_last_ff;

   // record state
   logic [IDX_BITS-1:0] idx_ff,  idx_in;
   sum_type             sum_ff,  sum_in;
   sample_type          record_peak_ff, record_peak_in;
   sample_type          window_peak_ff [WINDOWS];
   sample_type          window_peak_in [WINDOWS];
   logic                limits_ok;

   // result register
   logic                 rsp_valid_ff;
   sum_type              out_sum_ff;
   logic [PEAK_BITS-1:0] out_peak_ff;
   logic [PEAK_BITS-1:0] out_wpeak_ff [OUT_PEAKS];
   logic [PEAK_BITS-1:0] out_wpeak_in [OUT_PEAKS];
   logic                 out_limits_ff;

   logic advance;   // processing stage may move
   logic fold_en;   // a sample is folded in this cycle
   logic finish;    // that sample closes the record

   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign fold_en = advance && in_valid_ff;
   assign finish  = fold_en && in_last_ff;

   assign req_bus.ready = !in_valid_ff || advance;
   assign csr_bus.ready = 1'b1;

   // register writes, indexes past the last window are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < WINDOWS; w++) begin
            window_cfg_ff[w] <= '0;
         end
      end else if (csr_bus.valid) begin
         for (int w = 0; w < WINDOWS; w++) begin
            if (csr_bus.reg_index == REG_WINDOW_0 + CSR_ADDR_BITS'(w)) begin
               window_cfg_ff[w] <= window_cfg_type'(csr_bus.wr_data);
            end
         end
      end
   end

   // input register, refilled whenever the processing stage empties it
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         in_sample_ff <= req_bus.sample;
         in_last_ff   <= req_bus.last_sample;
      end
   end

   // per-sample update: saturating sum, peaks, windows and the limit check
   always_comb begin
      logic signed [SUM_BITS:0] sum_wide;
      logic [CMP_BITS-1:0]      idx_cmp;
      logic                     hit;

      sum_wide = {sum_ff[SUM_BITS-1], sum_ff} + (SUM_BITS+1)'(in_sample_ff);
      if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
         // overflow: clamp toward the sign of the true sum
         sum_in = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                     : {1'b0, {(SUM_BITS-1){1'b1}}};
      end else begin
         sum_in = sum_wide[SUM_BITS-1:0];
      end

      record_peak_in = (in_sample_ff > record_peak_ff) ? in_sample_ff : record_peak_ff;

      idx_cmp   = CMP_BITS'(idx_ff);
      limits_ok = 1'b1;
      for (int w = 0; w < WINDOWS; w++) begin
         hit = window_cfg_ff[w].enable
               && idx_cmp >= CMP_BITS'(window_cfg_ff[w].begin_idx)
               && idx_cmp <= CMP_BITS'(window_cfg_ff[w].end_idx)
               && in_sample_ff > window_peak_ff[w];
         window_peak_in[w] = hit ? in_sample_ff : window_peak_ff[w];
         if (window_cfg_ff[w].enable
             && (window_peak_in[w] < window_cfg_ff[w].lower
                 || window_peak_in[w] > window_cfg_ff[w].upper)) begin
            limits_ok = 1'b0;
         end
      end

      // index stops at the last slot
      idx_in = (idx_ff == IDX_MAX) ? idx_ff : idx_ff + IDX_BITS'(1);
   end

   // window peak outputs, a slot with no window behind it reads zero
   for (genvar o = 0; o < OUT_PEAKS; o++) begin : g_out_peak
      if (o < WINDOWS) begin : g_live
         assign out_wpeak_in[o] = window_peak_in[o][PEAK_BITS-1:0];
      end else begin : g_none
         assign out_wpeak_in[o] = '0;
      end
   end

   // record state, cleared after the last sample
   always_ff @(posedge clock) begin
      if (reset || finish) begin
         idx_ff         <= '0;
         sum_ff         <= '0;
         record_peak_ff <= '0;
         for (int w = 0; w < WINDOWS; w++) begin
            window_peak_ff[w] <= '0;
         end
      end else if (fold_en) begin
         idx_ff         <= idx_in;
         sum_ff         <= sum_in;
         record_peak_ff <= record_peak_in;
         for (int w = 0; w < WINDOWS; w++) begin
            window_peak_ff[w] <= window_peak_in[w];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= finish;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         out_sum_ff    <= sum_in;
         out_peak_ff   <= record_peak_in[PEAK_BITS-1:0];
         out_limits_ff <= limits_ok;
         for (int o = 0; o < OUT_PEAKS; o++) begin
            out_wpeak_ff[o] <= out_wpeak_in[o];
         end
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.raw_sum       = out_sum_ff;
   assign rsp_bus.peak_value    = out_peak_ff;
   assign rsp_bus.window_peak_a = out_wpeak_ff[0];
   assign rsp_bus.window_peak_b = out_wpeak_ff[1];
   assign rsp_bus.window_peak_c = out_wpeak_ff[2];
   assign rsp_bus.window_peak_d = out_wpeak_ff[3];
   assign rsp_bus.in_limits     = out_limits_ff;

   // a new result only ever comes from a last sample
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff && in_last_ff))
      else $error("result raised without a last sample");

   // closing a record leaves the state cleared
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      finish |=> (idx_ff == '0 && sum_ff == '0 && record_peak_ff == '0))
      else $error("record state not cleared after last sample");

   // peaks start at zero and only grow
   a_peak_floor: assert property (@(posedge clock) disable iff (reset)
      !record_peak_ff[SAMPLE_BITS-1])
      else $error("record peak below zero");

   // a window only sees a subset of the record
   for (genvar w = 0; w < WINDOWS; w++) begin : g_chk
      a_window_le_record: assert property (@(posedge clock) disable iff (reset)
         window_peak_ff[w] <= record_peak_ff)
         else $error("window peak above record peak");
   end

   // a held input sample is not lost while the result stalls
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_sample_ff)))
      else $error("input sample lost during stall");

endmodule
